// File: hdl/lru_keyed_cache_lookup_core_defines.svh
// Assertion macros shared by the cache lookup RTL.
`ifndef LRU_KEYED_CACHE_LOOKUP_CORE_DEFINES_SVH
`define LRU_KEYED_CACHE_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LKC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LKC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/lkc_pkg.sv
// Package: constants and types for the cache lookup cell chain.
package lkc_pkg;

	localparam int ENTRIES_DEF = 10;
	localparam int ENTRIES_MAX = 64;
	localparam int IDX_W       = $clog2(ENTRIES_MAX);
	localparam int TAG_W       = 32;
	localparam int STYLE_W     = 2;
	localparam int STAMP_W     = 32;
	localparam int SLOT_W      = 4;
	localparam int IN_W        = 40;
	localparam int OUT_W       = 8;
	localparam logic [STAMP_W-1:0] COUNT_INIT = STAMP_W'(1);

	// search token handed from cell to cell
	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [STYLE_W-1:0] style;
		logic               hit;
		logic [IDX_W-1:0]   hit_idx;
		logic               best_valid;
		logic [STAMP_W-1:0] best_stamp;
		logic [IDX_W-1:0]   best_idx;
	} tok_t;

	// slot update broadcast to all cells
	typedef struct packed {
		logic               we;
		logic               replace;
		logic [IDX_W-1:0]   idx;
		logic [TAG_W-1:0]   tag;
		logic [STYLE_W-1:0] style;
		logic [STAMP_W-1:0] stamp;
	} wr_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              hit;
	} res_t;

endpackage

// File: hdl/lkc_cell.sv
// One cache slot: holds tag, style and stamp, and updates the passing search token.
module lkc_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lkc_pkg::tok_t tok_in,
	output lkc_pkg::tok_t tok_out,
	input  lkc_pkg::wr_t  wr
);

	localparam int IW = lkc_pkg::IDX_W;
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [lkc_pkg::TAG_W-1:0]   tag_q;
	logic [lkc_pkg::STYLE_W-1:0] style_q;
	logic [lkc_pkg::STAMP_W-1:0] stamp_q;
	lkc_pkg::tok_t               tok_q;
	lkc_pkg::tok_t               tok_nxt;

	always_comb begin
		tok_nxt = tok_in;
		if (!tok_in.hit && tok_in.tag == tag_q && tok_in.style == style_q) begin
			tok_nxt.hit     = 1'b1;
			tok_nxt.hit_idx = MY_IDX;
		end
		// strict compare keeps the higher index on ties
		if (!tok_in.best_valid || stamp_q < tok_in.best_stamp) begin
			tok_nxt.best_valid = 1'b1;
			tok_nxt.best_stamp = stamp_q;
			tok_nxt.best_idx   = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q   <= '0;
			style_q <= '0;
			stamp_q <= '0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (wr.we && wr.idx == MY_IDX) begin
				stamp_q <= wr.stamp;
				if (wr.replace) begin
					tag_q   <= wr.tag;
					style_q <= wr.style;
				end
			end
		end
	end

	assign tok_out = tok_q;

endmodule

// File: hdl/lru_keyed_cache_lookup_core.sv
// Top level: fully associative LRU cache lookup built as a chain of slot cells.
//
// Input stream s_axis carries one request item: name tag and style bits.
// Output stream m_axis carries one result item per request: hit flag and
// the index of the matched or replaced slot.
// A request token enters the top cell on accept and moves down one cell per
// cycle, picking up the first tag/style match and the least-stamp victim.
// When it leaves cell 0 the chosen slot is stamped (and refilled on a miss)
// and the result is registered. One request is in the chain at a time, so a
// new request is taken only after the token of the last one has left cell 0.
// A result waiting on a stalled m_axis does not block the next request; a
// second finished result is parked in a holding register, and s_axis_tready
// stays low while that register is full.
// Reset clears all slots to tag 0, style 0, stamp 0 and sets the use counter
// to 1; the block is ready in the first cycle after reset.
`include "lru_keyed_cache_lookup_core_defines.svh"

module lru_keyed_cache_lookup_core #(
	parameter int NUM_ENTRIES = lkc_pkg::ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [lkc_pkg::IN_W-1:0]  s_axis_tdata,  // name_tag[31:0], style_bits[33:32]
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [lkc_pkg::OUT_W-1:0] m_axis_tdata   // hit[0], slot[4:1]
);

	localparam int IW = lkc_pkg::IDX_W;
	localparam int TW = lkc_pkg::TAG_W;
	localparam int SW = lkc_pkg::STYLE_W;
	localparam int RW = $bits(lkc_pkg::res_t);

	lkc_pkg::tok_t                chain [NUM_ENTRIES+1];
	lkc_pkg::wr_t                 wr;
	lkc_pkg::res_t                res;
	lkc_pkg::res_t                out_q;
	lkc_pkg::res_t                pend_q;
	logic                         out_valid_q;
	logic                         pend_valid_q;
	logic                         busy_q;
	logic [lkc_pkg::STAMP_W-1:0]  cnt_q;
	logic [IW-1:0]                chosen;
	logic                         in_acc;
	logic                         out_take;
	logic                         done;

	assign s_axis_tready = !busy_q && !pend_valid_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_take      = out_valid_q && m_axis_tready;

	always_comb begin
		chain[NUM_ENTRIES]       = '0;
		chain[NUM_ENTRIES].valid = in_acc;
		chain[NUM_ENTRIES].tag   = s_axis_tdata[TW-1:0];
		chain[NUM_ENTRIES].style = s_axis_tdata[TW+SW-1:TW];
	end

	for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
		lkc_cell #(
			.IDX(g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (chain[g+1]),
			.tok_out(chain[g]),
			.wr     (wr)
		);
	end

	assign done   = chain[0].valid;
	assign chosen = chain[0].hit ? chain[0].hit_idx : chain[0].best_idx;

	always_comb begin
		wr.we      = done;
		wr.replace = !chain[0].hit;
		wr.idx     = chosen;
		wr.tag     = chain[0].tag;
		wr.style   = chain[0].style;
		wr.stamp   = cnt_q + lkc_pkg::STAMP_W'(1);
		res.hit    = chain[0].hit;
		res.slot   = lkc_pkg::SLOT_W'(chosen);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			cnt_q        <= lkc_pkg::COUNT_INIT;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			out_q        <= '0;
			pend_q       <= '0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				cnt_q <= cnt_q + lkc_pkg::STAMP_W'(1);
			end
			if (done && (!out_valid_q || out_take)) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (done) begin
				pend_valid_q <= 1'b1;
				pend_q       <= res;
			end else if (out_take) begin
				if (pend_valid_q) begin
					out_q        <= pend_q;
					pend_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(lkc_pkg::OUT_W - RW)'(0), out_q};

	`LKC_ASSERT_IMP(a_done_busy, done, busy_q, "search token left the chain while idle")
	`LKC_ASSERT_IMP(a_pend_out, pend_valid_q, out_valid_q, "holding register full with output empty")
	`LKC_ASSERT_IMP(a_victim, done, chain[0].hit || chain[0].best_valid, "miss without victim")
	`LKC_ASSERT_NXT(a_count, done, cnt_q == $past(cnt_q) + lkc_pkg::STAMP_W'(1), "use counter not advanced")

endmodule
